/* rtl/wnm_pkg.sv */
package wnm_pkg;

  // default number of pattern positions
  localparam int PATTERN_MAX_DEF = 32;

  // bytes held by the four pattern registers
  localparam int PAT_REG_BYTES = 32;
  localparam int PAT_REG_W     = 64;
  localparam int PAT_LEN_W     = 6;

  // configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PAT_A   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_B   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_C   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_D   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN = 3'd4;

  // character codes
  localparam logic [7:0] CHAR_STAR      = 8'h2A;
  localparam logic [7:0] CHAR_QMARK     = 8'h3F;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_SLASH     = 8'h2F;
  localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z   = 8'h5A;
  localparam logic [7:0] CASE_OFFSET    = 8'd32;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       last_byte;
  } name_req_t;

  typedef struct packed {
    logic matches_so_far;
    logic name_done;
  } match_rsp_t;

  // lower-case A-Z, backslash to slash
  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    if (c == CHAR_BACKSLASH) begin
      r = CHAR_SLASH;
    end
    return r;
  endfunction

endpackage

/* rtl/wildcard_name_matcher.sv */
// a request waits in the input register, its result then in the result register
// throughput: one request per cycle unless out_ready stalls; the nfa update of all
//   positions against the state register is combinational; bytes stream back to back
// reset (rst, synchronous, active high): empties the pipeline, clears the pattern
//   registers and the length, and leaves only position zero active
module wildcard_name_matcher
  import wnm_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  name_req_t             in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output match_rsp_t            out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // positions 0..PATTERN_MAX of the nfa
  localparam int NPOS  = PATTERN_MAX + 1;
  localparam int POS_W = $clog2(NPOS);

  // star closure as a parallel prefix: a run of stars carries an active flag
  // forward, like a carry through propagate bits
  function automatic logic [NPOS-1:0] star_close(input logic [NPOS-1:0] s,
                                                 input logic [NPOS-1:0] p);
    logic [NPOS-1:0] g;
    logic [NPOS-1:0] q;
    logic [NPOS-1:0] g_next;
    logic [NPOS-1:0] q_next;
    g = s;
    q = p;
    for (int d = 0; d < POS_W; d++) begin
      g_next = g;
      q_next = q;
      for (int i = 0; i < NPOS; i++) begin
        if (i >= (1 << d)) begin
          g_next[i] = g[i] | (q[i] & g[i - (1 << d)]);
          q_next[i] = q[i] & q[i - (1 << d)];
        end
      end
      g = g_next;
      q = q_next;
    end
    return g;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration: pattern bytes are folded as they are written
  // ---------------------------------------------------------------------------
  logic [7:0]           pat [PAT_REG_BYTES];
  logic [PAT_LEN_W-1:0] pat_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PAT_REG_BYTES; k++) begin
        pat[k] <= 8'h00;
      end
      pat_len <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PAT_A, REG_PAT_B, REG_PAT_C, REG_PAT_D: begin
          for (int k = 0; k < PAT_REG_W / 8; k++) begin
            pat[{cfg_index[1:0], 3'(k)}] <= fold_byte(cfg_data[8*k +: 8]);
          end
        end
        REG_PAT_LEN: begin
          pat_len <= cfg_data[PAT_LEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // length above PATTERN_MAX saturates to PATTERN_MAX
  logic             len_over;
  logic [POS_W-1:0] eff_len;

  assign len_over = {1'b0, pat_len} > (PAT_LEN_W + 1)'(PATTERN_MAX);
  assign eff_len  = len_over ? POS_W'(PATTERN_MAX) : POS_W'(pat_len);

  // ---------------------------------------------------------------------------
  // pipeline control: input register, then result register
  // ---------------------------------------------------------------------------
  logic       req_vld;
  logic [7:0] req_byte;
  logic       req_last;
  logic       out_free;
  logic       advance;

  assign out_free = !out_valid || out_ready;
  assign advance  = req_vld && out_free;
  assign in_ready = !req_vld || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_vld <= 1'b0;
    end else if (in_ready) begin
      req_vld <= in_valid;
    end
  end

  // the name byte is folded on the way in
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_byte <= fold_byte(in_data.name_byte);
      req_last <= in_data.last_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // per-position decode of the pattern
  // ---------------------------------------------------------------------------
  logic [PATTERN_MAX-1:0] is_star;
  logic [PATTERN_MAX-1:0] is_any;
  logic [PATTERN_MAX-1:0] is_hit;
  logic [PATTERN_MAX-1:0] in_len;
  logic [NPOS-1:0]        prop;
  logic                   wrap;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_pos
    logic [7:0] pbyte;
    // bytes beyond the registers are a literal zero
    if (i < PAT_REG_BYTES) begin : g_reg
      assign pbyte = pat[i];
    end else begin : g_zero
      assign pbyte = 8'h00;
    end
    assign is_star[i]  = pbyte == CHAR_STAR;
    assign is_any[i]   = pbyte == CHAR_QMARK;
    assign is_hit[i]   = pbyte == req_byte;
    assign in_len[i]   = POS_W'(i) < eff_len;
    assign prop[i + 1] = is_star[i] && in_len[i];
  end

  assign prop[0] = 1'b0;

  // no wildcard in use: match anywhere, as if wrapped in stars
  assign wrap = ~|((is_star | is_any) & in_len);

  // ---------------------------------------------------------------------------
  // nfa update
  // ---------------------------------------------------------------------------
  logic [NPOS-1:0] state;
  logic [NPOS-1:0] state_next;
  logic [NPOS-1:0] pre;
  logic [NPOS-1:0] stepped;
  logic [NPOS-1:0] post;
  logic            matched;

  // close over stars first, since the pattern may have changed since the last byte
  assign pre = star_close(state | NPOS'(wrap), prop);

  always_comb begin
    stepped = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (pre[i] && in_len[i]) begin
        if (is_star[i]) begin
          stepped[i] = 1'b1;
        end else if (is_any[i] || is_hit[i]) begin
          stepped[i + 1] = 1'b1;
        end
      end
    end
    if (wrap) begin
      // leading star always live, trailing star holds a found match
      stepped[0] = 1'b1;
      if (pre[eff_len]) begin
        stepped[eff_len] = 1'b1;
      end
    end
  end

  assign post    = star_close(stepped, prop);
  assign matched = post[eff_len];

  // end of name restarts at position zero
  assign state_next = req_last ? NPOS'(1) : post;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= NPOS'(1);
    end else if (advance) begin
      state <= state_next;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= req_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.matches_so_far <= matched;
      out_data.name_done      <= req_last;
    end
  end

endmodule

/* rtl/wnm_checker.sv */
module wnm_checker
  import wnm_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input match_rsp_t            out_data,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  // empty pattern matches every name
  logic len_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      len_zero <= 1'b1;
    end else if (cfg_we && cfg_index == REG_PAT_LEN) begin
      len_zero <= cfg_data[PAT_LEN_W-1:0] == '0;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("request refused with result side free");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_empty_pattern: assert property (@(posedge clk) disable iff (rst)
    out_valid && len_zero |-> out_data.matches_so_far)
    else $error("empty pattern did not match");

endmodule

bind wildcard_name_matcher wnm_checker u_wnm_checker (.*);
